// ===== hw/rtl/sha256_pkg.sv =====
// SHA-256 package: round constants, initial hash values, rotate helper.
// No dependencies.
`default_nettype none
package sha256_pkg;
	localparam int unsigned QueueDepth = 4;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  count;
		logic        last;
	} msg_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD
	} core_state_t;

	typedef enum logic [1:0] {
		PH_DATA,
		PH_PAD,
		PH_LEN
	} pad_phase_t;

	function automatic logic [31:0] init_h(input logic [2:0] i);
		case (i)
			3'd0: init_h = 32'h6a09e667;
			3'd1: init_h = 32'hbb67ae85;
			3'd2: init_h = 32'h3c6ef372;
			3'd3: init_h = 32'ha54ff53a;
			3'd4: init_h = 32'h510e527f;
			3'd5: init_h = 32'h9b05688c;
			3'd6: init_h = 32'h1f83d9ab;
			3'd7: init_h = 32'h5be0cd19;
			default: init_h = 32'h0;
		endcase
	endfunction

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
		32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
		32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
		32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
		32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
		32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
		32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
		32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
		32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/sha256_fifo.sv =====
// Small input queue between front end and compression core.
// Depends on sha256_pkg.
`default_nettype none
module sha256_fifo #(
	parameter int unsigned Depth = sha256_pkg::QueueDepth
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    wr,
	input  sha256_pkg::msg_item_t  wdata,
	output logic                   full,
	input  wire                    rd,
	output sha256_pkg::msg_item_t  rdata,
	output logic                   empty
);
	import sha256_pkg::*;
	localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

	msg_item_t       mem_q [Depth];
	logic [AW-1:0]   wp_q, rp_q;
	logic [AW:0]     cnt_q;

	assign full  = (cnt_q == (AW+1)'(Depth));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !full) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr && !full) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
			if (rd && !empty) rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr && !full) - (AW+1)'(rd && !empty);
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/sha256_core.sv =====
// Back end: byte packing, padding, 64-round compression one round per cycle.
// Depends on sha256_pkg.
`default_nettype none
module sha256_core (
	input  wire                    clk,
	input  wire                    arst_n,
	input  sha256_pkg::msg_item_t  item,
	input  wire                    item_avail,
	output logic                   item_take,
	output logic [255:0]           digest,
	output logic                   digest_valid,
	input  wire                    digest_pop
);
	import sha256_pkg::*;

	core_state_t  st_q, st_d;
	pad_phase_t   ph_q;
	logic [31:0]  blk_q [16];
	logic [31:0]  h_q [8];
	logic [31:0]  v_q [8];
	logic [31:0]  hf [8];
	logic [5:0]   pos_q;
	logic [60:0]  len_q;
	logic [5:0]   rnd_q;
	logic [2:0]   bi_q;
	logic [2:0]   nb_q;
	logic [31:0]  wd_q;
	logic         fin_q;
	logic         busy_q;
	logic         lenfin_q;
	logic [255:0] dig_q;
	logic         dv_q;
	logic [63:0]  bits;
	logic [7:0]   byte_v;
	logic         put;
	logic         blk_end;
	logic [2:0]   lidx;
	logic [31:0]  s0, s1, wnew, t1, t2;

	assign bits = {len_q, 3'b000};
	assign digest = dig_q;
	assign digest_valid = dv_q;
	assign item_take = (st_q == ST_IDLE) && !busy_q && item_avail && !dv_q;
	assign put = (st_q == ST_IDLE) && busy_q && !(ph_q == PH_DATA && bi_q >= nb_q);
	assign blk_end = put && (pos_q == 6'd63);
	assign lidx = pos_q[2:0];

	// byte to place this cycle
	always_comb begin
		case (ph_q)
			PH_DATA: byte_v = wd_q[8*(3 - bi_q[1:0]) +: 8];
			PH_PAD:  byte_v = (bi_q == 3'd0) ? 8'h80 : 8'h00;
			PH_LEN:  byte_v = bits[8*(7 - lidx) +: 8];
			default: byte_v = 8'h00;
		endcase
	end

	// message schedule on a 16-word window
	assign s0 = rotr(blk_q[1], 7) ^ rotr(blk_q[1], 18) ^ (blk_q[1] >> 3);
	assign s1 = rotr(blk_q[14], 17) ^ rotr(blk_q[14], 19) ^ (blk_q[14] >> 10);
	assign wnew = blk_q[0] + s0 + blk_q[9] + s1;
	assign t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25)) +
		((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + RoundK[rnd_q] + blk_q[0];
	assign t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22)) +
		((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	always_comb for (int i = 0; i < 8; i++) hf[i] = h_q[i] + v_q[i];

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE:  if (blk_end) st_d = ST_ROUND;
			ST_ROUND: if (rnd_q == 6'd63) st_d = ST_ADD;
			ST_ADD:   st_d = ST_IDLE;
			default:  st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (put)
			blk_q[pos_q[5:2]][8*(3 - pos_q[1:0]) +: 8] <= byte_v;
		if (st_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) blk_q[i] <= blk_q[i+1];
			blk_q[15] <= wnew;
			for (int i = 1; i < 8; i++) v_q[i] <= v_q[i-1];
			v_q[4] <= v_q[3] + t1;
			v_q[0] <= t1 + t2;
		end else if (blk_end) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end
		if (item_take) wd_q <= item.word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ph_q <= PH_DATA;
			pos_q <= '0;
			len_q <= '0;
			rnd_q <= '0;
			bi_q <= '0;
			nb_q <= '0;
			fin_q <= 1'b0;
			busy_q <= 1'b0;
			lenfin_q <= 1'b0;
			dv_q <= 1'b0;
			dig_q <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
		end else begin
			st_q <= st_d;
			if (dv_q && digest_pop) dv_q <= 1'b0;
			if (item_take) begin
				nb_q <= (item.count > 3'd4) ? 3'd4 : item.count;
				fin_q <= item.last;
				bi_q <= '0;
				ph_q <= PH_DATA;
				busy_q <= 1'b1;
			end
			if (st_q == ST_ROUND) rnd_q <= rnd_q + 6'd1;
			// add round result into the hash; on the final block emit digest and start over
			if (st_q == ST_ADD) begin
				if (lenfin_q) begin
					dig_q <= {hf[0], hf[1], hf[2], hf[3], hf[4], hf[5], hf[6], hf[7]};
					dv_q <= 1'b1;
					lenfin_q <= 1'b0;
					len_q <= '0;
					for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
				end else begin
					for (int i = 0; i < 8; i++) h_q[i] <= hf[i];
				end
			end
			if (put) pos_q <= pos_q + 6'd1;
			// a zero-count data phase moves on without placing a byte
			if (st_q == ST_IDLE && busy_q) begin
				case (ph_q)
					PH_DATA: begin
						if (bi_q >= nb_q) begin
							if (fin_q) ph_q <= PH_PAD;
							else busy_q <= 1'b0;
							bi_q <= '0;
						end else begin
							len_q <= len_q + 61'd1;
							bi_q <= bi_q + 3'd1;
							if (bi_q + 3'd1 == nb_q && !fin_q) busy_q <= 1'b0;
						end
					end
					PH_PAD: begin
						bi_q <= 3'd1;
						if (pos_q == 6'd55) ph_q <= PH_LEN;
					end
					PH_LEN: begin
						if (pos_q == 6'd63) begin
							busy_q <= 1'b0;
							ph_q <= PH_DATA;
							fin_q <= 1'b0;
							lenfin_q <= 1'b1;
						end
					end
					default: ph_q <= PH_DATA;
				endcase
			end
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/sha256_digest_engine_top.sv =====
// SHA-256 digest engine top: input queue feeding the compression core.
// Depends on sha256_pkg, sha256_fifo, sha256_core.
//
// Input channel: push/full carries one message word transaction (word, byte
// count, last mark) into a four-entry queue. Result channel: empty/pop carries
// one 256-bit digest transaction per message, given on the final word.
// The core takes one word at a time and places its bytes one by one; every
// filled 64-byte block is then compressed (64 rounds and one add). When
// padding does not fit the last block a second compression follows. One
// word is handled before the next. A digest waits on the result ports until
// popped; meanwhile no word is taken, so a stalled receiver fills the queue
// and raises full. Reset clears the queue, loads the initial hash values and
// raises empty.
`default_nettype none
module sha256_digest_engine_top #(
	parameter int unsigned QDepth = sha256_pkg::QueueDepth
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire  [31:0] message_word,
	input  wire  [2:0]  byte_count,
	input  wire         last_word,
	input  wire         push,
	output logic        full,
	output logic [63:0] digest_high,
	output logic [63:0] digest_upper_mid,
	output logic [63:0] digest_lower_mid,
	output logic [63:0] digest_low,
	output logic        empty,
	input  wire         pop
);
	import sha256_pkg::*;
	msg_item_t wi, ri;
	logic qe, take, dv;
	logic [255:0] dg;
	assign wi = '{word: message_word, count: byte_count, last: last_word};
	sha256_fifo #(.Depth(QDepth)) u_q (.clk, .arst_n, .wr(push), .wdata(wi), .full,
		.rd(take), .rdata(ri), .empty(qe));
	sha256_core u_core (.clk, .arst_n, .item(ri), .item_avail(!qe), .item_take(take),
		.digest(dg), .digest_valid(dv), .digest_pop(pop));
	assign empty = !dv;
	assign {digest_high, digest_upper_mid, digest_lower_mid, digest_low} = dg;
endmodule
`default_nettype wire

// ===== tb/tb_sha256_digest_engine_top.sv =====
// Testbench for sha256_digest_engine_top: random and directed messages.
// Digests are predicted in-bench. Depends on sha256_digest_engine_top and its package.
`default_nettype none
module tb_sha256_digest_engine_top;
	localparam int unsigned CycleLimit = 2000000;

	class sha_scoreboard;
		bit [31:0] hash_words [8];
		bit [31:0] blk_words [16];
		bit [60:0] byte_len;
		int unsigned blk_pos;
		bit [255:0] digest_q [$];
		int unsigned errors;

		static const bit [31:0] kc [64] = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
			32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
			32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
			32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
			32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
			32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
			32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
			32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
			32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
			32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
		};

		function new();
			errors = 0;
			restart();
		endfunction

		function void restart();
			hash_words = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
				32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
			byte_len = '0;
			blk_pos = 0;
		endfunction

		function bit [31:0] ror(bit [31:0] x, int unsigned n);
			return (x >> n) | (x << (32 - n));
		endfunction

		function void compress();
			bit [31:0] w [64];
			bit [31:0] v [8];
			bit [31:0] t1, t2;
			for (int i = 0; i < 16; i++)
				w[i] = blk_words[i];
			for (int i = 16; i < 64; i++)
				w[i] = w[i-16] + w[i-7]
					+ (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
					+ (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
			v = hash_words;
			for (int i = 0; i < 64; i++) begin
				t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
					+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + kc[i] + w[i];
				t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
					+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
				v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
			end
			for (int i = 0; i < 8; i++)
				hash_words[i] += v[i];
		endfunction

		function void put_byte(bit [7:0] b);
			blk_words[blk_pos / 4][31 - 8 * (blk_pos % 4) -: 8] = b;
			blk_pos++;
			if (blk_pos == 64) begin
				compress();
				blk_pos = 0;
			end
		endfunction

		// accepted input transaction
		function void note_input(bit [31:0] word, bit [2:0] cnt, bit lst);
			int unsigned n;
			bit [63:0] bitlen;
			n = (cnt > 4) ? 4 : cnt;
			for (int i = 0; i < n; i++) begin
				put_byte(word[31 - 8 * i -: 8]);
				byte_len++;
			end
			if (lst) begin
				bitlen = {byte_len, 3'b000};
				put_byte(8'h80);
				while (blk_pos != 56)
					put_byte(8'h00);
				for (int i = 0; i < 8; i++)
					put_byte(bitlen[63 - 8 * i -: 8]);
				digest_q.push_back({hash_words[0], hash_words[1], hash_words[2], hash_words[3],
					hash_words[4], hash_words[5], hash_words[6], hash_words[7]});
				restart();
			end
		endfunction

		task report(string what, bit [63:0] got, bit [63:0] want);
			$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
			errors++;
		endtask

		task check_result(bit [63:0] d0, bit [63:0] d1, bit [63:0] d2, bit [63:0] d3);
			bit [255:0] e;
			if (digest_q.size() == 0) begin
				report("unexpected digest", d0, 64'h0);
				return;
			end
			e = digest_q.pop_front();
			if (d0 !== e[255:192]) report("digest_high", d0, e[255:192]);
			if (d1 !== e[191:128]) report("digest_upper_mid", d1, e[191:128]);
			if (d2 !== e[127:64]) report("digest_lower_mid", d2, e[127:64]);
			if (d3 !== e[63:0]) report("digest_low", d3, e[63:0]);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic [31:0] message_word = '0;
	logic [2:0] byte_count = '0;
	logic last_word = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full, empty;
	logic [63:0] digest_high, digest_upper_mid, digest_lower_mid, digest_low;

	sha_scoreboard sb = new();
	int unsigned send_idle_pct, recv_idle_pct;
	int unsigned cycles = 0;
	int unsigned items_sent;

	sha256_digest_engine_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.message_word(message_word), .byte_count(byte_count), .last_word(last_word),
		.push(push), .full(full),
		.digest_high(digest_high), .digest_upper_mid(digest_upper_mid),
		.digest_lower_mid(digest_lower_mid), .digest_low(digest_low),
		.empty(empty), .pop(pop)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver
	always @(negedge clk)
		pop = arst_n && ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk)
		if (arst_n && pop && !empty)
			sb.check_result(digest_high, digest_upper_mid, digest_lower_mid, digest_low);

	task automatic send_word(bit [31:0] w, bit [2:0] c, bit l);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			push = 1'b0;
			@(negedge clk);
		end
		message_word = w;
		byte_count = c;
		last_word = l;
		push = 1'b1;
		forever begin
			@(posedge clk);
			if (!full) break;
		end
		sb.note_input(w, c, l);
		items_sent++;
	endtask

	task automatic drain_wait();
		@(negedge clk);
		push = 1'b0;
		while (sb.digest_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic send_message();
		int unsigned nw;
		bit [2:0] c;
		nw = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(18, 1);
		for (int i = 0; i < nw - 1; i++) begin
			c = ($urandom_range(99) < 85) ? 3'd4 : 3'($urandom_range(7));
			send_word($urandom, c, 1'b0);
		end
		c = ($urandom_range(1) == 0) ? 3'd4 : 3'($urandom_range(7));
		send_word($urandom, c, 1'b1);
	endtask

	task automatic run_phase(int unsigned s_pct, int unsigned r_pct, int unsigned n_items);
		int unsigned stop_at;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		stop_at = items_sent + n_items;
		drain_wait();
		while (items_sent < stop_at)
			send_message();
	endtask

	initial begin
		items_sent = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty message, "abc", short and oversize counts, zero-byte filler
		send_word(32'h0, 3'd0, 1'b1);
		send_word(32'h61626300, 3'd3, 1'b1);
		send_word(32'hffffffff, 3'd0, 1'b0);
		send_word(32'hffffffff, 3'd7, 1'b0);
		send_word(32'h12345678, 3'd1, 1'b0);
		send_word(32'h00000000, 3'd5, 1'b0);
		send_word(32'hffffffff, 3'd6, 1'b0);
		send_word(32'habcdef01, 3'd2, 1'b1);
		// 56-byte message forces an extra padding block
		for (int i = 0; i < 14; i++)
			send_word($urandom, 3'd4, i == 13);
		// 55 bytes: padding and length fit exactly
		for (int i = 0; i < 14; i++)
			send_word($urandom, (i == 13) ? 3'd3 : 3'd4, i == 13);

		run_phase(19, 62, 440);
		run_phase(62, 19, 440);
		run_phase(0, 0, 440);

		drain_wait();
		repeat (300) @(negedge clk);
		if (sb.errors == 0 && sb.digest_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
hw/rtl/sha256_pkg.sv
hw/rtl/sha256_fifo.sv
hw/rtl/sha256_core.sv
hw/rtl/sha256_digest_engine_top.sv
tb/tb_sha256_digest_engine_top.sv
